/* rtl/kmt_pkg.sv */
package kmt_pkg;

  localparam int ENTRIES    = 32;
  localparam int KEY_BITS   = 64;
  localparam int MAX_DUMP   = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam int CMD_W      = 3;
  localparam int KEY_W      = 64;
  localparam int PROTO_W    = 16;
  localparam int PORT_W     = 16;
  localparam int OWNER_W    = 32;
  localparam int ERR_W      = 2;
  localparam int CNT_OUT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT  = 3'd0,
    CMD_MAP    = 3'd1,
    CMD_UNMAP  = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_DUMP   = 3'd4,
    CMD_PURGE  = 3'd5
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_SPACE = 2'd1,
    ERR_NO_ENTRY = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP,
    ST_DUMP_NEXT,
    ST_DUMP_EMIT
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PROTO_W-1:0]  proto;
    logic [PORT_W-1:0]   port;
    logic [OWNER_W-1:0]  owner;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/kmt_store.sv */
module kmt_store
  import kmt_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rd_data_o
);

  entry_t mem [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/keyed_mapping_table_unit.sv */
// Keyed mapping table: ENTRIES slots of (key, protocol, port, owner) with a valid bit each,
// kept in an entry RAM with one write port and one read port. Count and purge need no scan;
// map, unmap and lookup scan every slot through the RAM read port, one slot per cycle. Dump
// sends a header, then walks the slots, skipping free slots and reading each valid slot from
// the RAM before sending it; an output stall holds the walk. One command is worked at a time;
// in_ready_o is high only while the sequencer is idle, and a finished result may wait in the
// output register while the next command starts.
module keyed_mapping_table_unit
  import kmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [KEY_W-1:0]     name_key_i,
  input  logic [PROTO_W-1:0]   proto_i,
  input  logic [PORT_W-1:0]    port_value_i,
  input  logic [OWNER_W-1:0]   owner_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ok_o,
  output logic [ERR_W-1:0]     error_code_o,
  output logic [CNT_OUT_W-1:0] entry_count_o,
  output logic [PORT_W-1:0]    port_out_o,
  output logic [KEY_W-1:0]     key_out_o,
  output logic [PROTO_W-1:0]   proto_out_o,
  output logic                 last_o
);

  state_e state_q, state_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   vcount_q, vcount_d;

  cmd_e                cmd_q, cmd_d;
  logic [KEY_BITS-1:0] rkey_q, rkey_d;
  logic [PROTO_W-1:0]  rproto_q, rproto_d;
  logic [PORT_W-1:0]   rport_q, rport_d;
  logic [OWNER_W-1:0]  rowner_q, rowner_d;

  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              hit_found_q, hit_found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [PORT_W-1:0] hit_port_q, hit_port_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic [CNT_W-1:0]  removed_q, removed_d;

  logic [IDX_W-1:0] dump_idx_q, dump_idx_d;
  logic [CNT_W-1:0] dump_cnt_q, dump_cnt_d;
  logic [CNT_W-1:0] dump_emit;
  logic             dump_last;

  logic                 out_valid_q, out_valid_d;
  logic                 ok_q, ok_d;
  err_e                 err_q, err_d;
  logic [CNT_OUT_W-1:0] ecnt_q, ecnt_d;
  logic [PORT_W-1:0]    oport_q, oport_d;
  logic [KEY_W-1:0]     okey_q, okey_d;
  logic [PROTO_W-1:0]   oproto_q, oproto_d;
  logic                 last_q, last_d;

  mem_req_t mem_req;
  entry_t   rd_data;
  logic     out_free;
  logic     in_xfer;
  logic     slot_valid;

  kmt_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign slot_valid = valid_q[cmp_idx_q];

  assign dump_emit = (32'(vcount_q) > MAX_DUMP) ? CNT_W'(MAX_DUMP) : vcount_q;
  assign dump_last = ((dump_cnt_q + CNT_W'(1)) == dump_emit);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority case (command_i)
            CMD_COUNT, CMD_DUMP, CMD_PURGE:  state_d = ST_RESP;
            CMD_MAP, CMD_UNMAP, CMD_LOOKUP:  state_d = ST_SCAN;
            default:                         state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_q == CNT_W'(ENTRIES)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = (cmd_q == CMD_DUMP && vcount_q != '0) ? ST_DUMP_NEXT : ST_IDLE;
        end
      end
      ST_DUMP_NEXT: begin
        if (valid_q[dump_idx_q]) begin
          state_d = ST_DUMP_EMIT;
        end
      end
      ST_DUMP_EMIT: begin
        if (out_free) begin
          state_d = dump_last ? ST_IDLE : ST_DUMP_NEXT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and table updates
  always_comb begin
    valid_d      = valid_q;
    vcount_d     = vcount_q;
    cmd_d        = cmd_q;
    rkey_d       = rkey_q;
    rproto_d     = rproto_q;
    rport_d      = rport_q;
    rowner_d     = rowner_q;
    scan_d       = scan_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_port_d   = hit_port_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    removed_d    = removed_q;
    dump_idx_d   = dump_idx_q;
    dump_cnt_d   = dump_cnt_q;

    out_valid_d = out_valid_q && !out_ready_i;
    ok_d        = ok_q;
    err_d       = err_q;
    ecnt_d      = ecnt_q;
    oport_d     = oport_q;
    okey_d      = okey_q;
    oproto_d    = oproto_q;
    last_d      = last_q;

    mem_req.we          = 1'b0;
    mem_req.waddr       = hit_found_q ? hit_idx_q : free_idx_q;
    mem_req.wdata.key   = rkey_q;
    mem_req.wdata.proto = rproto_q;
    mem_req.wdata.port  = rport_q;
    mem_req.wdata.owner = rowner_q;
    mem_req.re          = 1'b0;
    mem_req.raddr       = scan_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d        = cmd_e'(command_i);
          rkey_d       = name_key_i[KEY_BITS-1:0];
          rproto_d     = proto_i;
          rport_d      = port_value_i;
          rowner_d     = owner_id_i;
          scan_d       = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          removed_d    = '0;
        end
      end

      ST_SCAN: begin
        if (scan_q != CNT_W'(ENTRIES)) begin
          mem_req.re = 1'b1;
          scan_d     = scan_q + CNT_W'(1);
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_q[IDX_W-1:0];
        end
        if (cmp_vld_q) begin
          if (slot_valid && !hit_found_q && rd_data.key == rkey_q &&
              rd_data.proto == rproto_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = cmp_idx_q;
            hit_port_d  = rd_data.port;
          end
          if (!slot_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
          if (cmd_q == CMD_UNMAP && rowner_q != '0 && slot_valid &&
              rd_data.owner == rowner_q) begin
            valid_d[cmp_idx_q] = 1'b0;
            vcount_d           = vcount_q - CNT_W'(1);
            removed_d          = removed_q + CNT_W'(1);
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = 1'b1;
          err_d       = ERR_NONE;
          ecnt_d      = '0;
          oport_d     = '0;
          okey_d      = '0;
          oproto_d    = '0;
          last_d      = 1'b1;
          unique case (cmd_q)
            CMD_COUNT: begin
              ecnt_d = CNT_OUT_W'(vcount_q);
            end
            CMD_MAP: begin
              if (hit_found_q) begin
                mem_req.we = 1'b1;
              end else if (free_found_q) begin
                mem_req.we          = 1'b1;
                valid_d[free_idx_q] = 1'b1;
                vcount_d            = vcount_q + CNT_W'(1);
              end else begin
                ok_d  = 1'b0;
                err_d = ERR_NO_SPACE;
              end
            end
            CMD_UNMAP: begin
              if (rowner_q != '0) begin
                if (removed_q != '0) begin
                  ecnt_d = CNT_OUT_W'(removed_q);
                end else begin
                  ok_d  = 1'b0;
                  err_d = ERR_NO_ENTRY;
                end
              end else if (hit_found_q) begin
                valid_d[hit_idx_q] = 1'b0;
                vcount_d           = vcount_q - CNT_W'(1);
                ecnt_d             = CNT_OUT_W'(1);
              end else begin
                ok_d  = 1'b0;
                err_d = ERR_NO_ENTRY;
              end
            end
            CMD_LOOKUP: begin
              if (hit_found_q) begin
                oport_d = hit_port_q;
              end else begin
                ok_d  = 1'b0;
                err_d = ERR_NO_ENTRY;
              end
            end
            CMD_DUMP: begin
              if (vcount_q == '0) begin
                ok_d  = 1'b0;
                err_d = ERR_NO_ENTRY;
              end else begin
                ecnt_d     = CNT_OUT_W'(vcount_q);
                last_d     = 1'b0;
                dump_idx_d = '0;
                dump_cnt_d = '0;
              end
            end
            CMD_PURGE: begin
              ecnt_d   = CNT_OUT_W'(vcount_q);
              valid_d  = '0;
              vcount_d = '0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end

      ST_DUMP_NEXT: begin
        if (valid_q[dump_idx_q]) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = dump_idx_q;
        end else begin
          dump_idx_d = dump_idx_q + IDX_W'(1);
        end
      end

      ST_DUMP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = 1'b1;
          err_d       = ERR_NONE;
          ecnt_d      = CNT_OUT_W'(vcount_q);
          oport_d     = rd_data.port;
          okey_d      = KEY_W'(rd_data.key);
          oproto_d    = rd_data.proto;
          last_d      = dump_last;
          dump_idx_d  = dump_idx_q + IDX_W'(1);
          dump_cnt_d  = dump_cnt_q + CNT_W'(1);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      vcount_q     <= '0;
      out_valid_q  <= 1'b0;
      cmd_q        <= CMD_COUNT;
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      removed_q    <= '0;
      dump_idx_q   <= '0;
      dump_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      vcount_q     <= vcount_d;
      out_valid_q  <= out_valid_d;
      cmd_q        <= cmd_d;
      scan_q       <= scan_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      removed_q    <= removed_d;
      dump_idx_q   <= dump_idx_d;
      dump_cnt_q   <= dump_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_q     <= rkey_d;
    rproto_q   <= rproto_d;
    rport_q    <= rport_d;
    rowner_q   <= rowner_d;
    hit_idx_q  <= hit_idx_d;
    hit_port_q <= hit_port_d;
    free_idx_q <= free_idx_d;
    ok_q       <= ok_d;
    err_q      <= err_d;
    ecnt_q     <= ecnt_d;
    oport_q    <= oport_d;
    okey_q     <= okey_d;
    oproto_q   <= oproto_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign error_code_o  = err_q;
  assign entry_count_o = ecnt_q;
  assign port_out_o    = oport_q;
  assign key_out_o     = okey_q;
  assign proto_out_o   = oproto_q;
  assign last_o        = last_q;

  // running count tracks the valid bits
  a_vcount_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(vcount_q) == $countones(valid_q))
    else $error("valid count out of step with valid bits");

  a_vcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(vcount_q) <= ENTRIES)
    else $error("valid count above table size");

  a_scan_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (cmd_q == CMD_MAP || cmd_q == CMD_UNMAP || cmd_q == CMD_LOOKUP))
    else $error("scan running for a command that needs none");

  a_non_last_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |->
      (state_q == ST_DUMP_NEXT || state_q == ST_DUMP_EMIT))
    else $error("non-final transfer outside a dump");

  a_dump_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP_NEXT || state_q == ST_DUMP_EMIT) |-> dump_cnt_q < dump_emit)
    else $error("dump walked past its entry count");

endmodule

/* test/keyed_mapping_table_unit_tb.sv */
module keyed_mapping_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmt_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 70;
  localparam int QUIET_TAIL   = 20;
  localparam int FILL_AT      = 30;

  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MASK   = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam logic [KEY_W-1:0] KEY_ONES   = {KEY_W{1'b1}};

  typedef struct packed {
    logic                 ok;
    logic [ERR_W-1:0]     err;
    logic [CNT_OUT_W-1:0] cnt;
    logic [PORT_W-1:0]    port;
    logic [KEY_W-1:0]     key;
    logic [PROTO_W-1:0]   proto;
    logic                 last;
  } reply_t;

  class table_scoreboard;
    logic               valid_q [ENTRIES];
    logic [KEY_W-1:0]   key_q   [ENTRIES];
    logic [PROTO_W-1:0] proto_q [ENTRIES];
    logic [PORT_W-1:0]  port_q  [ENTRIES];
    logic [OWNER_W-1:0] owner_q [ENTRIES];
    reply_t             expected_replies [$];
    int                 errors;
    int                 checked;
    int                 full_rejects;
    int                 dumps;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      errors = 0;
      checked = 0;
      full_rejects = 0;
      dumps = 0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (valid_q[i]) if (valid_q[i]) n++;
      return n;
    endfunction

    function int find_slot(logic [KEY_W-1:0] key, logic [PROTO_W-1:0] proto);
      int slot;
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (valid_q[i] && key_q[i] == key && proto_q[i] == proto) slot = i;
      return slot;
    endfunction

    function void push_reply(bit ok, err_e err, int cnt, logic [PORT_W-1:0] port,
                             logic [KEY_W-1:0] key, logic [PROTO_W-1:0] proto, bit last);
      reply_t r;
      r.ok = ok;
      r.err = err;
      r.cnt = CNT_OUT_W'(cnt);
      r.port = port;
      r.key = key;
      r.proto = proto;
      r.last = last;
      expected_replies.push_back(r);
    endfunction

    // predict the results of one accepted command transfer
    function void note_transfer(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key_in,
                                logic [PROTO_W-1:0] proto, logic [PORT_W-1:0] port,
                                logic [OWNER_W-1:0] owner);
      logic [KEY_W-1:0] key;
      int slot;
      int n;
      int total;
      int emit;
      int k;
      key = key_in & KEY_MASK;
      n = 0;
      case (cmd)
        CMD_COUNT: push_reply(1, ERR_NONE, occupancy(), '0, '0, '0, 1);
        CMD_MAP: begin
          slot = find_slot(key, proto);
          if (slot < 0)
            for (int i = ENTRIES - 1; i >= 0; i--) if (!valid_q[i]) slot = i;
          if (slot < 0) begin
            full_rejects++;
            push_reply(0, ERR_NO_SPACE, 0, '0, '0, '0, 1);
          end else begin
            valid_q[slot] = 1'b1;
            key_q[slot] = key;
            proto_q[slot] = proto;
            port_q[slot] = port;
            owner_q[slot] = owner;
            push_reply(1, ERR_NONE, 0, '0, '0, '0, 1);
          end
        end
        CMD_UNMAP: begin
          if (owner != '0) begin
            foreach (valid_q[i])
              if (valid_q[i] && owner_q[i] == owner) begin
                valid_q[i] = 1'b0;
                n++;
              end
          end else begin
            slot = find_slot(key, proto);
            if (slot >= 0) begin
              valid_q[slot] = 1'b0;
              n = 1;
            end
          end
          if (n > 0) push_reply(1, ERR_NONE, n, '0, '0, '0, 1);
          else push_reply(0, ERR_NO_ENTRY, 0, '0, '0, '0, 1);
        end
        CMD_LOOKUP: begin
          slot = find_slot(key, proto);
          if (slot >= 0) push_reply(1, ERR_NONE, 0, port_q[slot], '0, '0, 1);
          else push_reply(0, ERR_NO_ENTRY, 0, '0, '0, '0, 1);
        end
        CMD_DUMP: begin
          dumps++;
          total = occupancy();
          if (total == 0) begin
            push_reply(0, ERR_NO_ENTRY, 0, '0, '0, '0, 1);
          end else begin
            emit = (total > MAX_DUMP) ? MAX_DUMP : total;
            push_reply(1, ERR_NONE, total, '0, '0, '0, 0);
            k = 0;
            foreach (valid_q[i])
              if (valid_q[i] && k < emit) begin
                k++;
                push_reply(1, ERR_NONE, total, port_q[i], key_q[i], proto_q[i], k == emit);
              end
          end
        end
        CMD_PURGE: begin
          foreach (valid_q[i])
            if (valid_q[i]) begin
              valid_q[i] = 1'b0;
              n++;
            end
          push_reply(1, ERR_NONE, n, '0, '0, '0, 1);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected result ok=%0b err=%0d cnt=%0d last=%0b",
                         got.ok, got.err, got.cnt, got.last));
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.ok !== want.ok)
        report($sformatf("result %0d ok %0b, want %0b", checked, got.ok, want.ok));
      if (got.err !== want.err)
        report($sformatf("result %0d error_code %0d, want %0d", checked, got.err, want.err));
      if (got.cnt !== want.cnt)
        report($sformatf("result %0d entry_count %0d, want %0d", checked, got.cnt, want.cnt));
      if (got.port !== want.port)
        report($sformatf("result %0d port_out %h, want %h", checked, got.port, want.port));
      if (got.key !== want.key)
        report($sformatf("result %0d key_out %h, want %h", checked, got.key, want.key));
      if (got.proto !== want.proto)
        report($sformatf("result %0d proto_out %h, want %h", checked, got.proto, want.proto));
      if (got.last !== want.last)
        report($sformatf("result %0d last %0b, want %0b", checked, got.last, want.last));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i = '0;
  logic [KEY_W-1:0]     name_key_i = '0;
  logic [PROTO_W-1:0]   proto_i = '0;
  logic [PORT_W-1:0]    port_value_i = '0;
  logic [OWNER_W-1:0]   owner_id_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 ok_o;
  logic [ERR_W-1:0]     error_code_o;
  logic [CNT_OUT_W-1:0] entry_count_o;
  logic [PORT_W-1:0]    port_out_o;
  logic [KEY_W-1:0]     key_out_o;
  logic [PROTO_W-1:0]   proto_out_o;
  logic                 last_o;

  table_scoreboard    sb = new();
  int                 cycle_count = 0;
  int                 items_sent = 0;
  bit                 quiet = 1'b0;
  bit                 hold_req = 1'b0;
  bit                 hold_done = 1'b0;
  logic [KEY_W-1:0]   key_pool   [6];
  logic [PROTO_W-1:0] proto_pool [3];
  logic [OWNER_W-1:0] owner_pool [4];

  keyed_mapping_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .name_key_i    (name_key_i),
    .proto_i       (proto_i),
    .port_value_i  (port_value_i),
    .owner_id_i    (owner_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .error_code_o  (error_code_o),
    .entry_count_o (entry_count_o),
    .port_out_o    (port_out_o),
    .key_out_o     (key_out_o),
    .proto_out_o   (proto_out_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sb.expected_replies.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({ok_o, error_code_o, entry_count_o, port_out_o, key_out_o,
                       proto_out_o, last_o});
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [PROTO_W-1:0] proto, input logic [PORT_W-1:0] port,
                          input logic [OWNER_W-1:0] owner);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    name_key_i <= key;
    proto_i <= proto;
    port_value_i <= port;
    owner_id_i <= owner;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_transfer(cmd, key, proto, port, owner);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    if ($urandom_range(0, 4) == 0) return PROTO_W'($urandom);
    return proto_pool[$urandom_range(0, 2)];
  endfunction

  task automatic send_random();
    int roll;
    logic [CMD_W-1:0] cmd;
    logic [OWNER_W-1:0] own;
    roll = $urandom_range(0, 99);
    own = owner_pool[$urandom_range(0, 3)];
    if (roll < 35) begin
      cmd = CMD_MAP;
      if ($urandom_range(0, 4) == 0) own = '0;
    end else if (roll < 55) begin
      cmd = CMD_UNMAP;
      if ($urandom_range(0, 1) == 0) own = '0;
      else if ($urandom_range(0, 4) == 0) own = $urandom;
    end else if (roll < 75) begin
      cmd = CMD_LOOKUP;
    end else if (roll < 83) begin
      cmd = CMD_COUNT;
    end else if (roll < 93) begin
      cmd = CMD_DUMP;
    end else if (roll < 96) begin
      cmd = CMD_PURGE;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
    end
    send_cmd(cmd, pick_key(), pick_proto(), PORT_W'($urandom), own);
  endtask

  // fill every slot, hit the full case, dump the full table under a long output stall
  task automatic fill_table();
    while (sb.occupancy() < ENTRIES)
      send_cmd(CMD_MAP, {$urandom, $urandom}, pick_proto(), PORT_W'($urandom),
               owner_pool[$urandom_range(0, 3)]);
    send_cmd(CMD_MAP, {$urandom, $urandom}, pick_proto(), PORT_W'($urandom), owner_pool[1]);
    send_cmd(CMD_MAP, sb.key_q[5], sb.proto_q[5], PORT_W'($urandom), owner_pool[2]);
    hold_req = 1'b1;
    send_cmd(CMD_DUMP, '0, '0, '0, '0);
    send_cmd(CMD_COUNT, '0, '0, '0, '0);
    send_cmd(CMD_LOOKUP, sb.key_q[ENTRIES-1], sb.proto_q[ENTRIES-1], '0, '0);
    send_cmd(CMD_UNMAP, '0, '0, '0, owner_pool[0]);
    send_cmd(CMD_DUMP, '0, '0, '0, '0);
    send_cmd(CMD_PURGE, '0, '0, '0, '0);
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < 6; i++) key_pool[i] = {$urandom, $urandom};
    proto_pool[0] = 16'd6;
    proto_pool[1] = 16'd17;
    proto_pool[2] = 16'hFFFF;
    foreach (owner_pool[i]) owner_pool[i] = $urandom | 32'd1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_COUNT, '0, '0, '0, '0);
    send_cmd(CMD_DUMP, '0, '0, '0, '0);
    send_cmd(CMD_LOOKUP, KEY_ONES, 16'hFFFF, '0, '0);
    send_cmd(CMD_UNMAP, KEY_ONES, 16'hFFFF, '0, '0);
    send_cmd(CMD_UNMAP, '0, '0, '0, 32'hFFFF_FFFF);
    send_cmd(CMD_MAP, KEY_ONES, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_MAP, '0, '0, '0, '0);
    send_cmd(CMD_MAP, '0, 16'd1, 16'h1234, 32'd1);
    send_cmd(CMD_MAP, '0, '0, 16'h8001, 32'd1);
    send_cmd(CMD_LOOKUP, KEY_ONES, 16'hFFFF, '0, '0);
    send_cmd(CMD_LOOKUP, '0, '0, '0, '0);
    send_cmd(CMD_COUNT, '0, '0, '0, '0);
    send_cmd(CMD_DUMP, '0, '0, '0, '0);
    send_cmd(CMD_RSVD_A, {$urandom, $urandom}, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD_B, KEY_ONES, '0, '0, '0);
    send_cmd(CMD_UNMAP, '0, '0, '0, 32'd1);
    send_cmd(CMD_MAP, 64'd5, 16'd5, 16'd55, 32'd7);
    send_cmd(CMD_UNMAP, KEY_ONES, 16'hFFFF, '0, '0);
    send_cmd(CMD_LOOKUP, KEY_ONES, 16'hFFFF, '0, '0);
    send_cmd(CMD_DUMP, '0, '0, '0, '0);
    send_cmd(CMD_PURGE, '0, '0, '0, '0);
    send_cmd(CMD_PURGE, '0, '0, '0, '0);
    send_cmd(CMD_COUNT, '0, '0, '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
      if (i == FILL_AT) fill_table();
      send_random();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands and %0d results, %0d dumps, %0d table-full rejects",
             items_sent, sb.checked, sb.dumps, sb.full_rejects);
    $display("long output hold-off done: %0d, mismatches: %0d", hold_done, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/kmt_pkg.sv
rtl/kmt_store.sv
rtl/keyed_mapping_table_unit.sv
test/keyed_mapping_table_unit_tb.sv
